// ----- rtl/core/nscs_pkg.sv -----
// ----------------------------------------------------------------------------
// nscs_pkg
// Shared types, constants and helpers for the NAL start code scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package nscs_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;

    // Start code patterns as they sit in the byte window
    localparam logic [31:0] LONG_CODE  = 32'h0000_0001;
    localparam logic [23:0] SHORT_CODE = 24'h00_0001;

    localparam logic [2:0] PREFIX_LEN_LONG  = 3'd4;
    localparam logic [2:0] PREFIX_LEN_SHORT = 3'd3;

    localparam logic [31:0] WINDOW_RESET = 32'hFFFF_FFFF;

    // Output queue: one input byte may close two units
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int RECORDS_PER_ITEM = 2;

    typedef struct packed {
        logic [31:0] unit_start;
        logic [31:0] header_position;
        logic [2:0]  prefix_length;
        logic [4:0]  unit_type;
        logic [31:0] unit_length;
        logic        run_last;
    } t_record;

    function automatic logic [31:0] low32(input logic [63:0] v);
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nscs_if.sv -----
// ----------------------------------------------------------------------------
// nscs_in_if / nscs_out_if
// Valid/ready channels for stream bytes in and unit records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface nscs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface nscs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] unit_start;
    logic [31:0] header_position;
    logic [2:0]  prefix_length;
    logic [4:0]  unit_type;
    logic [31:0] unit_length;
    logic        run_last;

    modport source (
        output valid, output unit_start, output header_position, output prefix_length,
        output unit_type, output unit_length, output run_last, input ready
    );
    modport sink (
        input valid, input unit_start, input header_position, input prefix_length,
        input unit_type, input unit_length, input run_last, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/nal_start_code_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// nal_start_code_scanner_unit
// H.264 Annex B start code scanner producing one record per NAL unit.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while i_in.ready is high. The scan state
// (byte window, position, open unit) is updated at the accepting edge, and the
// 0, 1 or 2 records the byte closes are written into a 4-entry output queue at
// the same edge, so a record reaches o_out behind any records already queued. i_in.ready
// is high while the queue has room for two records; with a consumer that takes
// one record per cycle the input never stalls. A byte marked end_of_stream
// returns the scanner to its reset state, and the next byte is position 0.
// Positions are held in POSITION_BITS bits, saturate at the top value, and are
// reported in their low 32 bits.
`default_nettype none

module nal_start_code_scanner_unit
    import nscs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    nscs_in_if.sink      i_in,
    nscs_out_if.source   o_out
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // scan state
    logic [31:0]              r_window,    n_window;
    logic [POSITION_BITS-1:0] r_pos,       n_pos;
    logic                     r_open,      n_open;
    logic [POSITION_BITS-1:0] r_open_start, n_open_start;
    logic [POSITION_BITS-1:0] r_open_hdr,  n_open_hdr;
    logic                     r_open_long, n_open_long;
    logic [4:0]               r_open_type, n_open_type;

    // output queue
    t_record                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]    r_count;

    logic                     in_fire, out_fire;
    logic                     hit4, hit3, hit;
    logic [POSITION_BITS-1:0] start_pos, end_pos, len_a, len_b;
    logic                     rec_a_vld, rec_b_vld;
    t_record                  rec_a, rec_b, push0, push1;
    logic [1:0]               push_n;
    logic [FIFO_PTR_W-1:0]    wr_ptr_nxt;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    assign i_in.ready = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - RECORDS_PER_ITEM));

    // ---------------- scan logic ----------------
    assign hit4 = (r_window == LONG_CODE);
    assign hit3 = !hit4 && (r_window[23:0] == SHORT_CODE);
    assign hit  = hit4 || hit3;

    assign start_pos = r_pos - (hit4 ? POSITION_BITS'(4) : POSITION_BITS'(3));
    assign end_pos   = (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;

    always_comb begin
        // unit closed by a new start code
        rec_a_vld = hit && r_open;
        len_a     = (start_pos >= r_open_hdr) ? start_pos - r_open_hdr : '0;
        rec_a.unit_start      = low32(64'(r_open_start));
        rec_a.header_position = low32(64'(r_open_hdr));
        rec_a.prefix_length   = r_open_long ? PREFIX_LEN_LONG : PREFIX_LEN_SHORT;
        rec_a.unit_type       = r_open_type;
        rec_a.unit_length     = low32(64'(len_a));
        rec_a.run_last        = !i_in.end_of_stream;

        // open unit after this byte's start code, if any
        n_open       = r_open || hit;
        n_open_start = hit ? start_pos : r_open_start;
        n_open_hdr   = hit ? r_pos : r_open_hdr;
        n_open_long  = hit ? hit4 : r_open_long;
        n_open_type  = hit ? i_in.data_byte[4:0] : r_open_type;

        // unit closed by end of stream
        rec_b_vld = i_in.end_of_stream && n_open;
        len_b     = (end_pos >= n_open_hdr) ? end_pos - n_open_hdr : '0;
        rec_b.unit_start      = low32(64'(n_open_start));
        rec_b.header_position = low32(64'(n_open_hdr));
        rec_b.prefix_length   = n_open_long ? PREFIX_LEN_LONG : PREFIX_LEN_SHORT;
        rec_b.unit_type       = n_open_type;
        rec_b.unit_length     = low32(64'(len_b));
        rec_b.run_last        = 1'b1;

        n_window = {r_window[23:0], i_in.data_byte};
        n_pos    = (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= WINDOW_RESET;
            r_pos        <= '0;
            r_open       <= 1'b0;
            r_open_start <= '0;
            r_open_hdr   <= '0;
            r_open_long  <= 1'b0;
            r_open_type  <= '0;
        end else if (in_fire) begin
            if (i_in.end_of_stream) begin
                r_window     <= WINDOW_RESET;
                r_pos        <= '0;
                r_open       <= 1'b0;
                r_open_start <= '0;
                r_open_hdr   <= '0;
                r_open_long  <= 1'b0;
                r_open_type  <= '0;
            end else begin
                r_window     <= n_window;
                r_pos        <= n_pos;
                r_open       <= n_open;
                r_open_start <= n_open_start;
                r_open_hdr   <= n_open_hdr;
                r_open_long  <= n_open_long;
                r_open_type  <= n_open_type;
            end
        end
    end

    // ---------------- output queue ----------------
    always_comb begin
        push_n = {1'b0, rec_a_vld} + {1'b0, rec_b_vld};
        push0  = rec_a_vld ? rec_a : rec_b;
        push1  = rec_b;
        if (!in_fire) begin
            push_n = 2'd0;
        end
    end

    assign wr_ptr_nxt = FIFO_PTR_W'(r_wr_ptr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= push0;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_ptr_nxt] <= push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= FIFO_PTR_W'(r_wr_ptr + push_n);
            if (out_fire) begin
                r_rd_ptr <= FIFO_PTR_W'(r_rd_ptr + 1'b1);
            end
            r_count <= FIFO_CNT_W'(r_count + push_n - {1'b0, out_fire});
        end
    end

    assign o_out.valid           = (r_count != '0);
    assign o_out.unit_start      = r_mem[r_rd_ptr].unit_start;
    assign o_out.header_position = r_mem[r_rd_ptr].header_position;
    assign o_out.prefix_length   = r_mem[r_rd_ptr].prefix_length;
    assign o_out.unit_type       = r_mem[r_rd_ptr].unit_type;
    assign o_out.unit_length     = r_mem[r_rd_ptr].unit_length;
    assign o_out.run_last        = r_mem[r_rd_ptr].run_last;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue count out of range");

    a_two_only_at_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n == 2'd2) |-> i_in.end_of_stream)
        else $error("two records from a byte that does not end the stream");

    a_eos_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.end_of_stream) |=> (r_pos == '0 && !r_open))
        else $error("scan state not cleared after end of stream");

    a_header_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_open_hdr > r_open_start))
        else $error("open unit header not after its prefix start");

    a_pos_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in.end_of_stream) |=> (r_pos >= $past(r_pos)))
        else $error("position moved backward inside a stream");

endmodule

`default_nettype wire

// ----- verif/nal_unit_record_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_unit_record_checker
// Watches the byte and record channels of the start code scanner. It predicts
// the unit records from the accepted bytes and compares them in arrival order.
// ----------------------------------------------------------------------------
module nal_unit_record_checker
    import nscs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nscs_in_if   i_in,
    nscs_out_if  i_out,
    output int   o_fail_count,
    output int   o_records_due
);

    typedef logic [POSITION_BITS-1:0] t_pos;
    localparam t_pos POS_TOP = '1;

    // scan state
    logic [31:0] window;
    t_pos        byte_pos;
    logic        unit_open;
    t_pos        open_start;
    t_pos        open_header;
    logic        open_long;
    logic [4:0]  open_type;

    t_record records_due[$];
    int      fails = 0;
    int      records_seen = 0;

    assign o_fail_count = fails;

    initial o_records_due = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: record %0d: %s", $time, records_seen, what);
        fails++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    task automatic clear_scan();
        window      = WINDOW_RESET;
        byte_pos    = '0;
        unit_open   = 1'b0;
        open_start  = '0;
        open_header = '0;
        open_long   = 1'b0;
        open_type   = '0;
    endtask

    function automatic t_record closed_unit(input t_pos len);
        t_record r;
        r.unit_start      = 32'(open_start);
        r.header_position = 32'(open_header);
        r.prefix_length   = open_long ? PREFIX_LEN_LONG : PREFIX_LEN_SHORT;
        r.unit_type       = open_type;
        r.unit_length     = 32'(len);
        r.run_last        = 1'b0;
        return r;
    endfunction

    // One accepted byte: may close the open unit, open a new one, and end the
    // stream, so up to two records come out of it.
    task automatic scan_byte(input logic [7:0] b, input logic eos);
        t_record recs[$];
        t_pos    p;
        t_pos    start;
        t_pos    stop;
        logic    hit4;
        logic    hit3;
        p    = byte_pos;
        hit4 = (window == LONG_CODE);
        hit3 = !hit4 && (window[23:0] == SHORT_CODE);
        if (hit4 || hit3) begin
            start = p - (hit4 ? t_pos'(4) : t_pos'(3));
            if (unit_open) begin
                recs.push_back(closed_unit(start >= open_header ? start - open_header : '0));
            end
            unit_open   = 1'b1;
            open_start  = start;
            open_header = p;
            open_long   = hit4;
            open_type   = b[4:0];
        end
        if (eos) begin
            // saturated counter: stream end pinned at the top value
            stop = (p == POS_TOP) ? POS_TOP : p + 1'b1;
            if (unit_open) begin
                recs.push_back(closed_unit(stop >= open_header ? stop - open_header : '0));
            end
            clear_scan();
        end else begin
            window = {window[23:0], b};
            if (p != POS_TOP) begin
                byte_pos = p + 1'b1;
            end
        end
        if (recs.size() > 0) begin
            recs[recs.size() - 1].run_last = 1'b1;
        end
        foreach (recs[k]) begin
            records_due.push_back(recs[k]);
        end
    endtask

    task automatic check_record(input t_record got);
        t_record want;
        if (records_due.size() == 0) begin
            report_mismatch($sformatf("no unit closed, got start 0x%0h header 0x%0h",
                                      got.unit_start, got.header_position));
        end else begin
            want = records_due.pop_front();
            compare_field("unit_start", got.unit_start, want.unit_start);
            compare_field("header_position", got.header_position, want.header_position);
            compare_field("prefix_length", 32'(got.prefix_length), 32'(want.prefix_length));
            compare_field("unit_type", 32'(got.unit_type), 32'(want.unit_type));
            compare_field("unit_length", got.unit_length, want.unit_length);
            compare_field("run_last", 32'(got.run_last), 32'(want.run_last));
        end
        records_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            records_due.delete();
        end else begin
            // a record is registered only after its byte is accepted, so order here is free
            if (i_out.valid && i_out.ready) begin
                check_record({i_out.unit_start, i_out.header_position, i_out.prefix_length,
                              i_out.unit_type, i_out.unit_length, i_out.run_last});
            end
            if (i_in.valid && i_in.ready) begin
                scan_byte(i_in.data_byte, i_in.end_of_stream);
            end
        end
        o_records_due = records_due.size();
    end

endmodule

// ----- verif/nal_start_code_scanner_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_start_code_scanner_unit_tb
// Feeds Annex B byte streams into the scanner: a directed part around prefix
// placement and stream ends, then random streams of units mixed with noise.
// Both channels idle at random; the record checker does the comparison.
// ----------------------------------------------------------------------------
module nal_start_code_scanner_unit_tb;

    localparam int RANDOM_BYTES = 1100;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       feed_valid  = 1'b0;
    logic [7:0] feed_byte   = 8'h00;
    logic       feed_eos    = 1'b0;
    logic       drain_ready = 1'b0;
    logic       calm        = 1'b0;
    int         fail_count;
    int         units_owed;
    int         bytes_sent  = 0;

    nscs_in_if  in_ch ();
    nscs_out_if out_ch ();

    assign in_ch.valid         = feed_valid;
    assign in_ch.data_byte     = feed_byte;
    assign in_ch.end_of_stream = feed_eos;
    assign out_ch.ready        = drain_ready;

    nal_start_code_scanner_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    nal_unit_record_checker record_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_records_due (units_owed)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        drain_ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_byte(input logic [7:0] b, input logic eos);
        calm <= (bytes_sent >= 500) && (bytes_sent < 700);
        while (!calm && $urandom_range(0, 99) < 10) begin
            feed_valid <= 1'b0;
            @(negedge i_clk);
        end
        feed_valid <= 1'b1;
        feed_byte  <= b;
        feed_eos   <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] zero_heavy_byte();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'h00;
            3:       return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_unit(input logic long_prefix, input logic [7:0] header,
                             input int payload_len, input logic last);
        if (long_prefix) begin
            push_byte(8'h00, 1'b0);
        end
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(header, last && payload_len == 0);
        for (int k = 0; k < payload_len; k++) begin
            push_byte($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)),
                      last && k == payload_len - 1);
        end
    endtask

    task automatic send_stream();
        int units;
        units = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 5)) push_byte(zero_heavy_byte(), 1'b0);
        end
        for (int u = 0; u < units; u++) begin
            send_unit($urandom_range(0, 1), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 16), u == units - 1);
        end
    endtask

    // noise and broken prefixes, now and then cut by a stream end
    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            push_byte(zero_heavy_byte(), $urandom_range(0, 19) == 0);
        end
    endtask

    initial begin
        logic paused;
        paused = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short prefix at offset zero, long prefix, stream ending on a header
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h65, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hE0, 1'b1);
        // stream end with nothing open
        push_byte(8'hFF, 1'b1);
        // start code with no header before the stream end
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h1F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b1);

        while (bytes_sent < RANDOM_BYTES + 22) begin
            if ($urandom_range(0, 9) < 8) begin
                send_stream();
            end else begin
                send_noise();
            end
            if (!paused && bytes_sent >= 300) begin
                // hold the sender until the scanner has drained completely
                paused = 1'b1;
                feed_valid <= 1'b0;
                wait (units_owed == 0);
                @(negedge i_clk);
            end
        end
        feed_valid <= 1'b0;

        wait (units_owed == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && units_owed == 0) begin
            $display("nal_start_code_scanner_unit_tb: done, clean");
        end else begin
            $display("nal_start_code_scanner_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #(300_000 * 12);
        $display("nal_start_code_scanner_unit_tb: done, errors");
        $finish;
    end

endmodule
